[src/ry420_pkg.sv]
// Shared types, coefficients and helpers for the RGB to YUV 4:2:0 converter.
// Depends on nothing; every other file in src imports it.
package ry420_pkg;

    // Field widths fixed by the interface
    localparam int COMP_W     = 8;
    localparam int CFG_W      = 12;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 11;
    localparam int PROD_W     = 24;
    localparam int PAIR_W     = 9;
    localparam int ENTRY_W    = 2 * PAIR_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_LSB = 2;

    // Request queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Frame limits and register reset values
    localparam logic [CFG_W-1:0] MAX_HEIGHT     = 12'd2048;
    localparam logic [CFG_W-1:0] MIN_DIM        = 12'd2;
    localparam logic [CFG_W-1:0] WIDTH_DEFAULT  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_DEFAULT = 12'd480;

    // Register indexes (paddr bit REG_IDX_LSB)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // 0.16 coefficients, rounded to nearest
    localparam logic [15:0] COEF_Y_R = 16'd19595;
    localparam logic [15:0] COEF_Y_G = 16'd38470;
    localparam logic [15:0] COEF_Y_B = 16'd7471;
    localparam logic [15:0] COEF_U_R = 16'd11036;
    localparam logic [15:0] COEF_U_G = 16'd21732;
    localparam logic [15:0] COEF_V_G = 16'd27440;
    localparam logic [15:0] COEF_V_B = 16'd5328;

    localparam logic [COMP_W-1:0] CHROMA_OFFSET = 8'd128;
    localparam logic [COMP_W-1:0] LUMA_MIN      = 8'd16;
    localparam logic [COMP_W-1:0] LUMA_MAX      = 8'd235;
    localparam logic [COMP_W-1:0] CHROMA_MIN    = 8'd16;
    localparam logic [COMP_W-1:0] CHROMA_MAX    = 8'd240;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [COMP_W-1:0] luma;
        logic              chroma_valid;
        logic [COMP_W-1:0] chroma_u;
        logic [COMP_W-1:0] chroma_v;
        logic              last_of_frame;
    } t_result;

    // Frame position that the front attaches to each pixel
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             odd_row;
        logic             last;
    } t_tag;

    typedef struct packed {
        t_pixel pixel;
        t_tag   tag;
    } t_item;

    function automatic logic [COMP_W-1:0] clamp8(
        input logic [COMP_W-1:0] v,
        input logic [COMP_W-1:0] lo,
        input logic [COMP_W-1:0] hi
    );
        logic [COMP_W-1:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

[src/rgb_to_yuv420_converter.sv]
// RGB to YUV 4:2:0 converter, top level. Throughput: one pixel per clock while the output
// side does not stall. An accepted pixel passes through the queue, the product stage, the
// sum stage and the output register.
// A 4-entry request queue keeps accepting while the output side stalls, until it is full.
// Reset (synchronous, active low) clears control state and sets 640x480; line buffer
// contents are not cleared and are always written before they are read.
module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ry420_pkg::PADDR_W-1:0] paddr,
    input  logic [ry420_pkg::PDATA_W-1:0] pwdata,
    output logic [ry420_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ry420_pkg::t_pixel             i_in_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ry420_pkg::t_result            o_out_result
);
    import ry420_pkg::*;

    logic  push;
    logic  fifo_full;
    logic  fifo_valid;
    logic  pop;
    t_tag  tag;
    t_item push_item;
    t_item pop_item;

    assign pready     = 1'b1;
    assign o_in_stall = fifo_full;
    assign push       = i_in_valid && !fifo_full;

    assign push_item.pixel = i_in_pixel;
    assign push_item.tag   = tag;

    // position tracking and registers
    ry420_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .i_push    (push),
        .o_tag     (tag)
    );

    // request queue
    ry420_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_item  (pop_item)
    );

    // conversion pipeline
    ry420_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (fifo_valid),
        .i_item       (pop_item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

    // frame end always falls on the bottom-right pixel of a 2x2 block
    a_last_has_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_result.last_of_frame |-> o_out_result.chroma_valid)
        else $error("last pixel of frame without chroma");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_result.luma >= LUMA_MIN && o_out_result.luma <= LUMA_MAX)
        else $error("luma out of range");

    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_result.chroma_valid |->
            o_out_result.chroma_u >= CHROMA_MIN && o_out_result.chroma_u <= CHROMA_MAX &&
            o_out_result.chroma_v >= CHROMA_MIN && o_out_result.chroma_v <= CHROMA_MAX)
        else $error("chroma out of range");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_result.chroma_valid |->
            o_out_result.chroma_u == '0 && o_out_result.chroma_v == '0)
        else $error("chroma not zero on a pixel without chroma");

endmodule

[src/ry420_front.sv]
// Front end: configuration registers and raster position tracking.
// Tags each accepted pixel with column, row parity and end of frame. Uses ry420_pkg.
module ry420_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [ry420_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [ry420_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [ry420_pkg::PDATA_W-1:0]  o_prdata,
    input  logic                           i_push,
    output ry420_pkg::t_tag                o_tag
);
    import ry420_pkg::*;

    localparam int WMAX_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             cfg_wr;
    logic             reg_sel;
    logic [CFG_W-1:0] w_even;
    logic [CFG_W-1:0] h_even;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;
    logic             col_end;
    logic             row_end;

    assign cfg_wr  = i_psel && i_penable && i_pwrite;
    assign reg_sel = i_paddr[REG_IDX_LSB];

    // register readback
    assign o_prdata = {{(PDATA_W-CFG_W){1'b0}},
                       (reg_sel == REG_FRAME_HEIGHT) ? r_frame_height : r_frame_width};

    // effective frame size: even, saturated to the supported range
    assign w_even = {r_frame_width[CFG_W-1:1], 1'b0};
    assign h_even = {r_frame_height[CFG_W-1:1], 1'b0};

    always_comb begin
        eff_w = w_even;
        if (w_even < MIN_DIM) begin
            eff_w = MIN_DIM;
        end else if ({{(32-CFG_W){1'b0}}, w_even} > 32'(WMAX_EVEN)) begin
            eff_w = CFG_W'(WMAX_EVEN);
        end
        eff_h = h_even;
        if (h_even < MIN_DIM) begin
            eff_h = MIN_DIM;
        end else if (h_even > MAX_HEIGHT) begin
            eff_h = MAX_HEIGHT;
        end
    end

    assign col_end = ({1'b0, r_col} + 13'd1) >= {1'b0, eff_w};
    assign row_end = ({1'b0, r_row} + 12'd1) >= eff_h;

    assign o_tag.column  = r_col;
    assign o_tag.odd_row = r_row[0];
    assign o_tag.last    = col_end && row_end;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_DEFAULT;
            r_frame_height <= HEIGHT_DEFAULT;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  r_frame_width  <= i_pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_pwdata[CFG_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    // raster counters; any register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_push) begin
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

[src/ry420_fifo.sv]
// Short request queue between the front end and the conversion pipeline.
// Register-based, FIFO_DEPTH entries of t_item. Uses ry420_pkg.
module ry420_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ry420_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output ry420_pkg::t_item o_item
);
    import ry420_pkg::*;

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/ry420_back.sv]
// Back end: color matrix, 2x2 chroma averaging and the output register.
// Three stages (products, sums, result) with the chroma line buffer. Uses ry420_pkg.
module ry420_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ry420_pkg::t_item   i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ry420_pkg::t_result o_out_result
);
    import ry420_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = $clog2(LINE_DEPTH);

    // line buffer of even-row pair sums: U in upper half, V in lower
    logic [ENTRY_W-1:0] r_line [LINE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    // stage 1: products
    logic              r_s1_valid;
    t_pixel            r_s1_pix;
    t_tag              r_s1_tag;
    logic [PROD_W-1:0] r_yr, r_yg, r_yb, r_ur, r_ug, r_vg, r_vb;

    // stage 2: raw Y, U, V
    logic              r_s2_valid;
    t_tag              r_s2_tag;
    logic [COMP_W-1:0] r_s2_y, r_s2_u, r_s2_v;

    // left pixel of the current column pair
    logic [COMP_W-1:0] r_left_u, r_left_v;

    // output register
    logic              r_out_valid;
    t_result           r_out;

    logic              en;
    logic [PROD_W-1:0] y_sum, u_sum, v_sum;
    logic [COMP_W-1:0] u_half, v_half;
    logic [IDX_W-1:0]  idx1, idx2;
    logic [PAIR_W-1:0] pair_u, pair_v;
    logic [PAIR_W:0]   blk_u, blk_v;
    logic              s2_odd_col;
    t_result           n_out;

    // the whole pipeline advances while the output register can take a result
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && i_valid;

    // stage 1: constant multiplies
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pix <= i_item.pixel;
            r_s1_tag <= i_item.tag;
            r_yr <= PROD_W'(COEF_Y_R) * PROD_W'(i_item.pixel.red);
            r_yg <= PROD_W'(COEF_Y_G) * PROD_W'(i_item.pixel.green);
            r_yb <= PROD_W'(COEF_Y_B) * PROD_W'(i_item.pixel.blue);
            r_ur <= PROD_W'(COEF_U_R) * PROD_W'(i_item.pixel.red);
            r_ug <= PROD_W'(COEF_U_G) * PROD_W'(i_item.pixel.green);
            r_vg <= PROD_W'(COEF_V_G) * PROD_W'(i_item.pixel.green);
            r_vb <= PROD_W'(COEF_V_B) * PROD_W'(i_item.pixel.blue);
        end
    end

    // stage 2: sums; U and V stay in 0..255 so 24 bits suffice
    assign u_half = {1'b0, r_s1_pix.blue[COMP_W-1:1]} + CHROMA_OFFSET;
    assign v_half = {1'b0, r_s1_pix.red[COMP_W-1:1]} + CHROMA_OFFSET;
    assign y_sum  = r_yr + r_yg + r_yb;
    assign u_sum  = {u_half, 16'b0} - r_ur - r_ug;
    assign v_sum  = {v_half, 16'b0} - r_vg - r_vb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_tag <= r_s1_tag;
            r_s2_y   <= y_sum[PROD_W-1:16];
            r_s2_u   <= u_sum[PROD_W-1:16];
            r_s2_v   <= v_sum[PROD_W-1:16];
        end
    end

    // line buffer: read as an item enters stage 2, write as it leaves
    assign idx1 = IDX_W'(r_s1_tag.column >> 1);
    assign idx2 = IDX_W'(r_s2_tag.column >> 1);
    assign s2_odd_col = r_s2_tag.column[0];
    assign pair_u = {1'b0, r_left_u} + {1'b0, r_s2_u};
    assign pair_v = {1'b0, r_left_v} + {1'b0, r_s2_v};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_data <= r_line[idx1];
            if (r_s2_valid && s2_odd_col && !r_s2_tag.odd_row) begin
                r_line[idx2] <= {pair_u, pair_v};
            end
        end
    end

    // 2x2 block average and result assembly
    assign blk_u = {1'b0, r_rd_data[ENTRY_W-1:PAIR_W]} + {1'b0, pair_u};
    assign blk_v = {1'b0, r_rd_data[PAIR_W-1:0]} + {1'b0, pair_v};

    always_comb begin
        n_out.luma          = clamp8(r_s2_y, LUMA_MIN, LUMA_MAX);
        n_out.chroma_valid  = s2_odd_col && r_s2_tag.odd_row;
        n_out.chroma_u      = '0;
        n_out.chroma_v      = '0;
        n_out.last_of_frame = r_s2_tag.last;
        if (n_out.chroma_valid) begin
            n_out.chroma_u = clamp8(blk_u[PAIR_W:2], CHROMA_MIN, CHROMA_MAX);
            n_out.chroma_v = clamp8(blk_v[PAIR_W:2], CHROMA_MIN, CHROMA_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    // left pixel of each pair, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_u <= '0;
            r_left_v <= '0;
        end else if (en && r_s2_valid && !s2_odd_col) begin
            r_left_u <= r_s2_u;
            r_left_v <= r_s2_v;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule

[bench/tb.sv]
// Self-checking bench for rgb_to_yuv420_converter: directed pixels, size extremes, then random frames.
// Depends on src/ry420_pkg.sv and the converter RTL; a local model predicts each result not given by a directed row.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ry420_pkg::*;

    // Geometry and fixed-point constants of the converter
    localparam int          TB_MAX_WIDTH  = 2048;
    localparam int          LINE_PAIRS    = TB_MAX_WIDTH / 2;
    localparam int unsigned SIZE_CEIL     = 2048;
    localparam int unsigned K_Y_RED       = 19595;
    localparam int unsigned K_Y_GREEN     = 38470;
    localparam int unsigned K_Y_BLUE      = 7471;
    localparam int unsigned K_U_RED       = 11036;
    localparam int unsigned K_U_GREEN     = 21732;
    localparam int unsigned K_V_GREEN     = 27440;
    localparam int unsigned K_V_BLUE      = 5328;
    localparam int unsigned CHROMA_BIAS   = 128;
    localparam int unsigned Y_FLOOR       = 16;
    localparam int unsigned Y_CEIL        = 235;
    localparam int unsigned C_FLOOR       = 16;
    localparam int unsigned C_CEIL        = 240;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          EXTREME_PIXELS = 300;
    localparam int          RANDOM_PIXELS = 1200;
    localparam int          MAX_REPORTS   = 10;

    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

    localparam t_pixel BLACK  = t_pixel'{8'd0, 8'd0, 8'd0};
    localparam t_pixel WHITE  = t_pixel'{8'd255, 8'd255, 8'd255};
    localparam t_pixel BLUE   = t_pixel'{8'd255, 8'd0, 8'd0};
    localparam t_pixel RED    = t_pixel'{8'd0, 8'd0, 8'd255};
    localparam t_pixel CYAN   = t_pixel'{8'd255, 8'd255, 8'd0};
    localparam t_pixel YELLOW = t_pixel'{8'd0, 8'd255, 8'd255};
    localparam t_result NO_TYPED = '0;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_SET_WIDTH, ROW_SET_HEIGHT} row_kind_t;
    typedef enum logic [1:0] {WRITE_BOTH, WRITE_WIDTH, WRITE_HEIGHT} cfg_write_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD}
        stall_style_t;

    typedef struct {
        row_kind_t   kind;
        t_pixel      px;
        logic [11:0] value;
        bit          typed;
        t_result     want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 pixel_valid;
    logic                 pixel_stall;
    t_pixel               pixel_data;
    logic                 result_valid;
    logic                 out_stall = 1'b0;
    t_result              result_data;

    // Converter model state
    logic [11:0]  cfg_width;
    logic [11:0]  cfg_height;
    logic [8:0]   pair_u_sum [LINE_PAIRS];
    logic [8:0]   pair_v_sum [LINE_PAIRS];
    int unsigned  left_u;
    int unsigned  left_v;
    int unsigned  col_pos;
    int unsigned  row_pos;

    t_result      expected_results [$];
    stim_row_t    directed_rows [$];
    int           fail_count = 0;
    int           burst_left = 0;

    stall_style_t stall_style = STALL_NONE;
    int           style_left = 0;
    int unsigned  stall_tick = 0;

    rgb_to_yuv420_converter #(
        .MAX_WIDTH(TB_MAX_WIDTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (pixel_valid),
        .o_in_stall   (pixel_stall),
        .i_in_pixel   (pixel_data),
        .o_out_valid  (result_valid),
        .i_out_stall  (out_stall),
        .o_out_result (result_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    // Frame size as the converter uses it: even, 2..2048
    function automatic int unsigned effective_size(input logic [11:0] v);
        int unsigned s;
        s = v & 12'hFFE;
        if (s < 2) s = 2;
        if (s > SIZE_CEIL) s = SIZE_CEIL;
        return s;
    endfunction

    function automatic logic [7:0] limit_range(input int unsigned v, lo, hi);
        if (v < lo) return 8'(lo);
        if (v > hi) return 8'(hi);
        return 8'(v);
    endfunction

    // Color conversion plus 4:2:0 pairing; advances the frame position
    function automatic t_result convert_pixel(input t_pixel px);
        int unsigned b, g, r, w, h, y, u, v, idx, su, sv;
        t_result res;
        b = px.blue;
        g = px.green;
        r = px.red;
        w = effective_size(cfg_width);
        h = effective_size(cfg_height);
        y = (K_Y_RED * r + K_Y_GREEN * g + K_Y_BLUE * b) >> 16;
        u = ((((b >> 1) + CHROMA_BIAS) << 16) - K_U_RED * r - K_U_GREEN * g) >> 16;
        v = ((((r >> 1) + CHROMA_BIAS) << 16) - K_V_GREEN * g - K_V_BLUE * b) >> 16;
        u &= 8'hFF;
        v &= 8'hFF;
        idx = (col_pos >> 1) % LINE_PAIRS;
        res = '0;
        res.luma = limit_range(y, Y_FLOOR, Y_CEIL);
        if ((col_pos & 1) == 0) begin
            left_u = u;
            left_v = v;
        end else if ((row_pos & 1) == 0) begin
            pair_u_sum[idx] = 9'(left_u + u);
            pair_v_sum[idx] = 9'(left_v + v);
        end else begin
            su = pair_u_sum[idx] + left_u + u;
            sv = pair_v_sum[idx] + left_v + v;
            res.chroma_valid = 1'b1;
            res.chroma_u = limit_range(su >> 2, C_FLOOR, C_CEIL);
            res.chroma_v = limit_range(sv >> 2, C_FLOOR, C_CEIL);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                row_pos = 0;
                res.last_of_frame = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    function automatic logic [7:0] random_component();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // One pixel request; bursts of random length separated by random gaps
    task automatic send_pixel(input t_pixel px, input bit typed, input t_result typed_res);
        t_result predicted;
        if (burst_left == 0) begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        pixel_valid <= 1'b1;
        pixel_data  <= px;
        do @(posedge clk); while (pixel_stall);
        predicted = convert_pixel(px);
        expected_results.push_back(typed ? typed_res : predicted);
        burst_left--;
    endtask

    // Stop requests and let every outstanding result come out
    task automatic drain();
        pixel_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; any write restarts the frame position
    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {20'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WIDTH_ADDR) cfg_width = value;
        else cfg_height = value;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic run_phase(input logic [11:0] w, h, input cfg_write_t which, input int count);
        drain();
        if (which != WRITE_HEIGHT) write_register(WIDTH_ADDR, w);
        if (which != WRITE_WIDTH) write_register(HEIGHT_ADDR, h);
        repeat (count) begin
            send_pixel(t_pixel'{random_component(), random_component(), random_component()},
                       1'b0, NO_TYPED);
        end
    endtask

    task automatic add_pixel(input t_pixel px, input bit typed, input t_result want);
        directed_rows.push_back('{ROW_PIXEL, px, 12'd0, typed, want});
    endtask

    task automatic add_write(input row_kind_t kind, input logic [11:0] value);
        directed_rows.push_back('{kind, BLACK, value, 1'b0, NO_TYPED});
    endtask

    // Stimulus
    initial begin
        logic [11:0] new_w, new_h;
        cfg_write_t  which;
        int          count, area, random_sent;

        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        pixel_data  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        cfg_width   = 12'd640;
        cfg_height  = 12'd480;
        left_u      = 0;
        left_v      = 0;
        col_pos     = 0;
        row_pos     = 0;
        for (int k = 0; k < LINE_PAIRS; k++) begin
            pair_u_sum[k] = '0;
            pair_v_sum[k] = '0;
        end

        // Reset sizes first, then 2x2 frames of saturated colors
        add_pixel(BLACK, 1'b1, t_result'{8'd16, 1'b0, 8'd0, 8'd0, 1'b0});
        add_pixel(WHITE, 1'b1, t_result'{8'd235, 1'b0, 8'd0, 8'd0, 1'b0});
        add_write(ROW_SET_WIDTH, 12'd2);
        add_write(ROW_SET_HEIGHT, 12'd2);
        repeat (3) add_pixel(BLACK, 1'b1, t_result'{8'd16, 1'b0, 8'd0, 8'd0, 1'b0});
        add_pixel(BLACK, 1'b1, t_result'{8'd16, 1'b1, 8'd128, 8'd128, 1'b1});
        repeat (3) add_pixel(WHITE, 1'b1, t_result'{8'd235, 1'b0, 8'd0, 8'd0, 1'b0});
        add_pixel(WHITE, 1'b1, t_result'{8'd235, 1'b1, 8'd127, 8'd127, 1'b1});
        // chroma clamps: U high, V high, V low, U low
        repeat (3) add_pixel(BLUE, 1'b0, NO_TYPED);
        add_pixel(BLUE, 1'b1, t_result'{8'd29, 1'b1, 8'd240, 8'd107, 1'b1});
        repeat (3) add_pixel(RED, 1'b0, NO_TYPED);
        add_pixel(RED, 1'b1, t_result'{8'd76, 1'b1, 8'd85, 8'd240, 1'b1});
        repeat (3) add_pixel(CYAN, 1'b0, NO_TYPED);
        add_pixel(CYAN, 1'b1, t_result'{8'd178, 1'b1, 8'd170, 8'd16, 1'b1});
        repeat (3) add_pixel(YELLOW, 1'b0, NO_TYPED);
        add_pixel(YELLOW, 1'b1, t_result'{8'd225, 1'b1, 8'd16, 8'd148, 1'b1});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_PIXEL: begin
                    send_pixel(directed_rows[i].px, directed_rows[i].typed,
                               directed_rows[i].want);
                end
                ROW_SET_WIDTH: begin
                    drain();
                    write_register(WIDTH_ADDR, directed_rows[i].value);
                end
                default: begin
                    drain();
                    write_register(HEIGHT_ADDR, directed_rows[i].value);
                end
            endcase
        end

        // Size extremes: start of a saturated wide line, narrow column of a saturated
        // tall frame, odd tiny frame
        run_phase(12'hFFF, 12'd2, WRITE_BOTH, EXTREME_PIXELS);
        run_phase(12'd0, 12'hFFF, WRITE_BOTH, EXTREME_PIXELS);
        run_phase(12'd1, 12'd1, WRITE_BOTH, 8);

        // Random frames, mostly small, some ending mid-frame
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 19) == 0) begin
                new_w = 12'($urandom());
                new_h = 12'($urandom());
            end else if ($urandom_range(0, 9) < 7) begin
                new_w = 12'($urandom_range(0, 24));
                new_h = 12'($urandom_range(0, 12));
            end else begin
                new_w = 12'($urandom_range(25, 128));
                new_h = 12'($urandom_range(0, 5));
            end
            case ($urandom_range(0, 4))
                0:       which = WRITE_WIDTH;
                1:       which = WRITE_HEIGHT;
                default: which = WRITE_BOTH;
            endcase
            area = effective_size(which == WRITE_HEIGHT ? cfg_width : new_w)
                 * effective_size(which == WRITE_WIDTH ? cfg_height : new_h);
            count = $urandom_range(1, 3) * area;
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area - 1);
            if (count > 600) count = $urandom_range(50, 600);
            run_phase(new_w, new_h, which, count);
            random_sent += count;
        end

        drain();
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: stall pattern and comparison against the oldest expectation
    always @(posedge clk) begin
        t_result want;
        if (style_left == 0) begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            style_left  <= $urandom_range(32, 400);
        end else begin
            style_left <= style_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
            default:     out_stall <= (stall_tick % 3 == 0);
        endcase

        if (rst_n && result_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result: luma %0d cv %0b u %0d v %0d last %0b",
                             result_data.luma, result_data.chroma_valid,
                             result_data.chroma_u, result_data.chroma_v,
                             result_data.last_of_frame);
                end
            end else begin
                want = expected_results.pop_front();
                if (result_data.luma !== want.luma
                        || result_data.chroma_valid !== want.chroma_valid
                        || result_data.chroma_u !== want.chroma_u
                        || result_data.chroma_v !== want.chroma_v
                        || result_data.last_of_frame !== want.last_of_frame) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected luma %0d cv %0b u %0d v %0d last %0b",
                                 want.luma, want.chroma_valid, want.chroma_u,
                                 want.chroma_v, want.last_of_frame);
                        $display("          got      luma %0d cv %0b u %0d v %0d last %0b",
                                 result_data.luma, result_data.chroma_valid,
                                 result_data.chroma_u, result_data.chroma_v,
                                 result_data.last_of_frame);
                    end
                end
            end
        end
    end

endmodule

[rgb_to_yuv420_converter.f]
src/ry420_pkg.sv
src/ry420_front.sv
src/ry420_fifo.sv
src/ry420_back.sv
src/rgb_to_yuv420_converter.sv
bench/tb.sv
